@@ sv/mre_pkg.sv @@
package mre_pkg;

  localparam int COORD_BITS = 12;
  localparam int RAD_W      = COORD_BITS - 1;
  localparam int SQ_W       = 2 * RAD_W;
  localparam int TXY_W      = SQ_W + COORD_BITS + 1;
  localparam int HX_W       = COORD_BITS + 1;
  localparam int MB_W       = 2 * HX_W;
  localparam int DEC_W      = SQ_W + MB_W;

  localparam logic ACT_START = 1'b0;
  localparam logic ACT_STEP  = 1'b1;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_SQ_RX,
    OP_SQ_RY,
    OP_RX2_RY,
    OP_START_DEC,
    OP_SQ_HX,
    OP_SQ_YM,
    OP_RY2_HX2,
    OP_RX2_YM2,
    OP_SUB_RR,
    OP_R2_DEC,
    OP_STEP_A,
    OP_STEP_B
  } op_e;

  typedef struct packed {
    logic                  action;
    logic [COORD_BITS-1:0] x_start;
    logic [COORD_BITS-1:0] y_start;
    logic [COORD_BITS-1:0] x_end;
    logic [COORD_BITS-1:0] y_end;
  } in_item_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] px_right;
    logic [COORD_BITS-1:0] px_left;
    logic [COORD_BITS-1:0] py_below;
    logic [COORD_BITS-1:0] py_above;
    logic                  last_set;
  } out_item_t;

  typedef struct packed {
    op_e  op;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic drawing;
    logic need_init;
    logic out_free;
  } status_t;

endpackage

@@ sv/midpoint_ellipse_rasterizer.sv @@
// Midpoint ellipse rasterizer. A start beat (action 0) takes two corners and returns the
// top/bottom point set after the accept state, three passes through the one shared
// multiplier (rx*rx, ry*ry, rx^2*ry) and a state that forms the decision value.
// A step beat (action 1) returns the next four-point set after an offset update, then a
// decision update; on the first step into region 2 the decision value is first rebuilt
// by five passes through that multiplier and a final subtract. A step while no ellipse
// is being drawn is taken and dropped, returning nothing. Input is stalled while a beat
// is in work; a finished set waits for the output register and is held back only while
// the previous set is still stalled there. last_set marks the final set of each ellipse.
module midpoint_ellipse_rasterizer (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  mre_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output mre_pkg::out_item_t out_data_o
);

  mre_pkg::cmd_t    cmd;
  mre_pkg::status_t status;

  mre_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_action_i (in_data_i.action),
    .in_stall_o  (in_stall_o),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  mre_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

@@ sv/mre_datapath.sv @@
module mre_datapath (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mre_pkg::in_item_t  in_data_i,
  input  mre_pkg::cmd_t      cmd_i,
  output mre_pkg::status_t   status_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output mre_pkg::out_item_t out_data_o
);

  logic [mre_pkg::COORD_BITS-1:0] cx_q, cx_d, cy_q, cy_d;
  logic [mre_pkg::COORD_BITS-1:0] ox_q, ox_d, oy_q, oy_d;
  logic [mre_pkg::RAD_W-1:0]      rx_q, rx_d, ry_q, ry_d;
  logic [mre_pkg::SQ_W-1:0]       rx2_q, rx2_d, ry2_q, ry2_d;
  logic [mre_pkg::TXY_W-1:0]      tx_q, tx_d, ty_q, ty_d;
  logic [mre_pkg::DEC_W-1:0]      dec_q, dec_d;
  logic [mre_pkg::MB_W-1:0]       sq_q, sq_d;
  logic [mre_pkg::DEC_W-1:0]      prod_q;
  logic                           region2_q, region2_d;
  logic                           drawing_q, drawing_d;
  logic                           br_r2_q, br_r2_d, br_xy_q, br_xy_d;
  logic                           out_valid_q, out_valid_d;
  mre_pkg::out_item_t             out_q, out_d;

  logic [mre_pkg::COORD_BITS-1:0] x_lo, x_hi, y_lo, y_hi, x_span, y_span;
  logic [mre_pkg::HX_W-1:0]       hx;
  logic [mre_pkg::COORD_BITS-1:0] ym;
  logic [mre_pkg::SQ_W-1:0]       mul_a;
  logic [mre_pkg::MB_W-1:0]       mul_b;
  logic [mre_pkg::DEC_W-1:0]      mul_p;
  logic [mre_pkg::DEC_W-1:0]      prod_x4;
  logic [mre_pkg::DEC_W-1:0]      term;
  logic                           dec_neg, dec_pos, x_move, y_move, out_free;

  assign x_lo   = (in_data_i.x_start < in_data_i.x_end) ? in_data_i.x_start : in_data_i.x_end;
  assign x_hi   = (in_data_i.x_start < in_data_i.x_end) ? in_data_i.x_end : in_data_i.x_start;
  assign y_lo   = (in_data_i.y_start < in_data_i.y_end) ? in_data_i.y_start : in_data_i.y_end;
  assign y_hi   = (in_data_i.y_start < in_data_i.y_end) ? in_data_i.y_end : in_data_i.y_start;
  assign x_span = x_hi - x_lo;
  assign y_span = y_hi - y_lo;

  assign hx      = {ox_q, 1'b1};
  assign ym      = oy_q - mre_pkg::COORD_BITS'(1);
  assign prod_x4 = {prod_q[mre_pkg::DEC_W-3:0], 2'b00};

  assign dec_neg = dec_q[mre_pkg::DEC_W-1];
  assign dec_pos = !dec_neg && (dec_q != '0);
  // region 1 always moves in x; region 2 always moves in y
  assign x_move  = !region2_q || !dec_pos;
  assign y_move  = region2_q || !dec_neg;

  assign out_free = !out_valid_q || !out_stall_i;

  // shared multiplier, operands picked by the current command
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.op)
      mre_pkg::OP_SQ_RX: begin
        mul_a = mre_pkg::SQ_W'(rx_q);
        mul_b = mre_pkg::MB_W'(rx_q);
      end
      mre_pkg::OP_SQ_RY: begin
        mul_a = mre_pkg::SQ_W'(ry_q);
        mul_b = mre_pkg::MB_W'(ry_q);
      end
      mre_pkg::OP_RX2_RY: begin
        mul_a = rx2_q;
        mul_b = mre_pkg::MB_W'(ry_q);
      end
      mre_pkg::OP_SQ_HX: begin
        mul_a = mre_pkg::SQ_W'(hx);
        mul_b = mre_pkg::MB_W'(hx);
      end
      mre_pkg::OP_SQ_YM: begin
        mul_a = mre_pkg::SQ_W'(ym);
        mul_b = mre_pkg::MB_W'(ym);
      end
      mre_pkg::OP_RY2_HX2: begin
        mul_a = ry2_q;
        mul_b = sq_q;
      end
      mre_pkg::OP_RX2_YM2: begin
        mul_a = rx2_q;
        mul_b = sq_q;
      end
      mre_pkg::OP_SUB_RR: begin
        mul_a = rx2_q;
        mul_b = mre_pkg::MB_W'(ry2_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // increment for the decision value, times four applied below
  always_comb begin
    term = br_r2_q ? mre_pkg::DEC_W'(rx2_q) : mre_pkg::DEC_W'(ry2_q);
    if (!br_r2_q || br_xy_q) begin
      term = term + mre_pkg::DEC_W'(tx_q);
    end
    if (br_r2_q || br_xy_q) begin
      term = term - mre_pkg::DEC_W'(ty_q);
    end
  end

  always_comb begin
    cx_d      = cx_q;
    cy_d      = cy_q;
    ox_d      = ox_q;
    oy_d      = oy_q;
    rx_d      = rx_q;
    ry_d      = ry_q;
    rx2_d     = rx2_q;
    ry2_d     = ry2_q;
    tx_d      = tx_q;
    ty_d      = ty_q;
    dec_d     = dec_q;
    sq_d      = sq_q;
    region2_d = region2_q;
    br_r2_d   = br_r2_q;
    br_xy_d   = br_xy_q;
    case (cmd_i.op)
      mre_pkg::OP_LOAD: begin
        rx_d      = x_span[mre_pkg::COORD_BITS-1:1];
        ry_d      = y_span[mre_pkg::COORD_BITS-1:1];
        cx_d      = x_lo + {1'b0, x_span[mre_pkg::COORD_BITS-1:1]};
        cy_d      = y_lo + {1'b0, y_span[mre_pkg::COORD_BITS-1:1]};
        ox_d      = '0;
        oy_d      = {1'b0, y_span[mre_pkg::COORD_BITS-1:1]};
        tx_d      = '0;
        region2_d = 1'b0;
      end
      mre_pkg::OP_SQ_RY: begin
        rx2_d = prod_q[mre_pkg::SQ_W-1:0];
      end
      mre_pkg::OP_RX2_RY: begin
        ry2_d = prod_q[mre_pkg::SQ_W-1:0];
      end
      mre_pkg::OP_START_DEC: begin
        ty_d  = {prod_q[mre_pkg::TXY_W-2:0], 1'b0};
        dec_d = mre_pkg::DEC_W'({ry2_q, 2'b00}) - prod_x4 + mre_pkg::DEC_W'(rx2_q);
      end
      mre_pkg::OP_SQ_YM: begin
        sq_d = prod_q[mre_pkg::MB_W-1:0];
      end
      mre_pkg::OP_RY2_HX2: begin
        sq_d = prod_q[mre_pkg::MB_W-1:0];
      end
      mre_pkg::OP_RX2_YM2: begin
        dec_d = prod_q;
      end
      mre_pkg::OP_SUB_RR: begin
        dec_d = dec_q + prod_x4;
      end
      mre_pkg::OP_R2_DEC: begin
        dec_d     = dec_q - prod_x4;
        region2_d = 1'b1;
      end
      mre_pkg::OP_STEP_A: begin
        if (x_move) begin
          ox_d = ox_q + mre_pkg::COORD_BITS'(1);
          tx_d = tx_q + mre_pkg::TXY_W'({ry2_q, 1'b0});
        end
        if (y_move) begin
          oy_d = oy_q - mre_pkg::COORD_BITS'(1);
          ty_d = ty_q - mre_pkg::TXY_W'({rx2_q, 1'b0});
        end
        br_r2_d = region2_q;
        br_xy_d = x_move && y_move;
      end
      mre_pkg::OP_STEP_B: begin
        dec_d = dec_q + {term[mre_pkg::DEC_W-3:0], 2'b00};
      end
      default: begin
        dec_d = dec_q;
      end
    endcase
  end

  always_comb begin
    drawing_d   = drawing_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (cmd_i.emit) begin
      out_valid_d    = 1'b1;
      out_d.px_right = cx_q + ox_q;
      out_d.px_left  = cx_q - ox_q;
      out_d.py_below = cy_q + oy_q;
      out_d.py_above = cy_q - oy_q;
      out_d.last_set = (oy_q == '0);
      drawing_d      = (oy_q != '0);
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q        <= '0;
      cy_q        <= '0;
      ox_q        <= '0;
      oy_q        <= '0;
      rx_q        <= '0;
      ry_q        <= '0;
      rx2_q       <= '0;
      ry2_q       <= '0;
      tx_q        <= '0;
      ty_q        <= '0;
      dec_q       <= '0;
      region2_q   <= 1'b0;
      drawing_q   <= 1'b0;
      br_r2_q     <= 1'b0;
      br_xy_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cx_q        <= cx_d;
      cy_q        <= cy_d;
      ox_q        <= ox_d;
      oy_q        <= oy_d;
      rx_q        <= rx_d;
      ry_q        <= ry_d;
      rx2_q       <= rx2_d;
      ry2_q       <= ry2_d;
      tx_q        <= tx_d;
      ty_q        <= ty_d;
      dec_q       <= dec_d;
      region2_q   <= region2_d;
      drawing_q   <= drawing_d;
      br_r2_q     <= br_r2_d;
      br_xy_q     <= br_xy_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_p;
    sq_q   <= sq_d;
    out_q  <= out_d;
  end

  assign status_o.drawing   = drawing_q;
  assign status_o.need_init = !region2_q && !(tx_q < ty_q);
  assign status_o.out_free  = out_free;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_region2_from_init: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(region2_q) |-> $past(cmd_i.op) == mre_pkg::OP_R2_DEC)
    else $error("region 2 entered without its decision set-up");

  a_drawing_ends_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(drawing_q) |-> $past(cmd_i.emit) && $past(oy_q) == '0)
    else $error("drawing ended without a last point set");

  a_emit_into_free_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> out_free)
    else $error("point set written over an untaken beat");

endmodule

@@ sv/mre_ctrl.sv @@
module mre_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_action_i,
  output logic             in_stall_o,
  input  mre_pkg::status_t status_i,
  output mre_pkg::cmd_t    cmd_o
);

  localparam logic [3:0] ST_IDLE      = 4'd0;
  localparam logic [3:0] ST_SQ_RX     = 4'd1;
  localparam logic [3:0] ST_SQ_RY     = 4'd2;
  localparam logic [3:0] ST_RX2_RY    = 4'd3;
  localparam logic [3:0] ST_START_DEC = 4'd4;
  localparam logic [3:0] ST_SQ_YM     = 4'd5;
  localparam logic [3:0] ST_RY2_HX2   = 4'd6;
  localparam logic [3:0] ST_RX2_YM2   = 4'd7;
  localparam logic [3:0] ST_SUB_RR    = 4'd8;
  localparam logic [3:0] ST_R2_DEC    = 4'd9;
  localparam logic [3:0] ST_STEP_A    = 4'd10;
  localparam logic [3:0] ST_STEP_B    = 4'd11;
  localparam logic [3:0] ST_EMIT      = 4'd12;

  logic [3:0] state_q, state_d;

  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    state_d    = state_q;
    cmd_o.op   = mre_pkg::OP_NONE;
    cmd_o.emit = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (in_action_i == mre_pkg::ACT_START) begin
            cmd_o.op = mre_pkg::OP_LOAD;
            state_d  = ST_SQ_RX;
          end else if (!status_i.drawing) begin
            // drop: nothing to advance
            cmd_o.op = mre_pkg::OP_NONE;
          end else if (status_i.need_init) begin
            cmd_o.op = mre_pkg::OP_SQ_HX;
            state_d  = ST_SQ_YM;
          end else begin
            cmd_o.op = mre_pkg::OP_STEP_A;
            state_d  = ST_STEP_B;
          end
        end
      end
      ST_SQ_RX: begin
        cmd_o.op = mre_pkg::OP_SQ_RX;
        state_d  = ST_SQ_RY;
      end
      ST_SQ_RY: begin
        cmd_o.op = mre_pkg::OP_SQ_RY;
        state_d  = ST_RX2_RY;
      end
      ST_RX2_RY: begin
        cmd_o.op = mre_pkg::OP_RX2_RY;
        state_d  = ST_START_DEC;
      end
      ST_START_DEC: begin
        cmd_o.op   = mre_pkg::OP_START_DEC;
        cmd_o.emit = status_i.out_free;
        state_d    = status_i.out_free ? ST_IDLE : ST_EMIT;
      end
      ST_SQ_YM: begin
        cmd_o.op = mre_pkg::OP_SQ_YM;
        state_d  = ST_RY2_HX2;
      end
      ST_RY2_HX2: begin
        cmd_o.op = mre_pkg::OP_RY2_HX2;
        state_d  = ST_RX2_YM2;
      end
      ST_RX2_YM2: begin
        cmd_o.op = mre_pkg::OP_RX2_YM2;
        state_d  = ST_SUB_RR;
      end
      ST_SUB_RR: begin
        cmd_o.op = mre_pkg::OP_SUB_RR;
        state_d  = ST_R2_DEC;
      end
      ST_R2_DEC: begin
        cmd_o.op = mre_pkg::OP_R2_DEC;
        state_d  = ST_STEP_A;
      end
      ST_STEP_A: begin
        cmd_o.op = mre_pkg::OP_STEP_A;
        state_d  = ST_STEP_B;
      end
      ST_STEP_B: begin
        cmd_o.op   = mre_pkg::OP_STEP_B;
        cmd_o.emit = status_i.out_free;
        state_d    = status_i.out_free ? ST_IDLE : ST_EMIT;
      end
      ST_EMIT: begin
        // hold until the output register frees up
        cmd_o.emit = status_i.out_free;
        state_d    = status_i.out_free ? ST_IDLE : ST_EMIT;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_idle_step_dropped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && in_valid_i && in_action_i == mre_pkg::ACT_STEP
     && !status_i.drawing) |=> state_q == ST_IDLE)
    else $error("step while idle did not drop");

  a_step_a_after_init: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_STEP_A |-> $past(state_q) == ST_R2_DEC)
    else $error("region 2 step without decision set-up");

  a_state_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q <= ST_EMIT)
    else $error("controller left its state encoding");

endmodule

@@ sim/tb_midpoint_ellipse_rasterizer.sv @@
`timescale 1ns / 100ps

module tb_midpoint_ellipse_rasterizer;
  import mre_pkg::*;

  localparam int COORD_MAX  = (1 << COORD_BITS) - 1;
  localparam int TIMEOUT_NS = 2_000_000;

  class ellipse_tracker;
    logic [COORD_BITS-1:0] ctr_x, ctr_y, off_x, off_y;
    logic [RAD_W-1:0]      rad_x, rad_y;
    longint                dec;
    bit                    region_two, drawing;
    out_item_t             pending_sets[$];
    int                    n_fail;

    function void flag(string msg);
      n_fail++;
      if (n_fail <= 10) $display("%s", msg);
    endfunction

    function void push_set(bit last);
      out_item_t s;
      s.px_right = ctr_x + off_x;
      s.px_left  = ctr_x - off_x;
      s.py_below = ctr_y + off_y;
      s.py_above = ctr_y - off_y;
      s.last_set = last;
      pending_sets.push_back(s);
    endfunction

    // Advance the ellipse trace by one accepted beat and queue the set it yields.
    function void note_beat(in_item_t beat);
      longint xs, ys, xe, ye, xlo, xhi, ylo, yhi;
      longint rx2, ry2, ox, oy, hx, ym;
      bit     last;
      if (beat.action == ACT_START) begin
        xs = longint'(beat.x_start);
        ys = longint'(beat.y_start);
        xe = longint'(beat.x_end);
        ye = longint'(beat.y_end);
        xlo = (xs < xe) ? xs : xe;
        xhi = (xs < xe) ? xe : xs;
        ylo = (ys < ye) ? ys : ye;
        yhi = (ys < ye) ? ye : ys;
        rad_x = RAD_W'((xhi - xlo) >> 1);
        rad_y = RAD_W'((yhi - ylo) >> 1);
        ctr_x = COORD_BITS'(xlo + longint'(rad_x));
        ctr_y = COORD_BITS'(ylo + longint'(rad_y));
        off_x = '0;
        off_y = COORD_BITS'(rad_y);
        rx2 = longint'(rad_x) * longint'(rad_x);
        ry2 = longint'(rad_y) * longint'(rad_y);
        dec = 4 * ry2 - 4 * rx2 * longint'(rad_y) + rx2;
        region_two = 1'b0;
        last = (rad_y == '0);
        drawing = !last;
        push_set(last);
        return;
      end
      if (!drawing) return;

      rx2 = longint'(rad_x) * longint'(rad_x);
      ry2 = longint'(rad_y) * longint'(rad_y);
      ox  = longint'(off_x);
      oy  = longint'(off_y);
      if (!region_two && ry2 * ox < rx2 * oy) begin
        ox++;
        if (dec < 0) begin
          dec += 4 * (2 * ry2 * ox + ry2);
        end else begin
          oy--;
          dec += 4 * (2 * ry2 * ox - 2 * rx2 * oy + ry2);
        end
      end else begin
        // rebuild the decision value on the first step past the slope change
        if (!region_two) begin
          hx  = 2 * ox + 1;
          ym  = oy - 1;
          dec = ry2 * hx * hx + 4 * rx2 * ym * ym - 4 * rx2 * ry2;
          region_two = 1'b1;
        end
        oy--;
        if (dec > 0) begin
          dec += 4 * (rx2 - 2 * rx2 * oy);
        end else begin
          ox++;
          dec += 4 * (2 * ry2 * ox - 2 * rx2 * oy + rx2);
        end
      end
      off_x = COORD_BITS'(ox);
      off_y = COORD_BITS'(oy);
      last = (off_y == '0);
      if (last) drawing = 1'b0;
      push_set(last);
    endfunction

    function void check_set(out_item_t got);
      out_item_t want;
      if (pending_sets.size() == 0) begin
        flag($sformatf("unexpected point set: x %0d/%0d y %0d/%0d last %0b",
                       got.px_right, got.px_left, got.py_below, got.py_above, got.last_set));
        return;
      end
      want = pending_sets.pop_front();
      if (got.px_right !== want.px_right || got.px_left !== want.px_left ||
          got.py_below !== want.py_below || got.py_above !== want.py_above ||
          got.last_set !== want.last_set)
        flag($sformatf({"point set mismatch: expected x %0d/%0d y %0d/%0d last %0b,",
                        " got x %0d/%0d y %0d/%0d last %0b"},
                       want.px_right, want.px_left, want.py_below, want.py_above,
                       want.last_set, got.px_right, got.px_left, got.py_below,
                       got.py_above, got.last_set));
    endfunction

    function void close_out();
      if (pending_sets.size() != 0)
        flag($sformatf("%0d point sets never arrived", pending_sets.size()));
    endfunction
  endclass

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_item_t  in_data_i;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_data_o;

  ellipse_tracker board;
  int  items_sent;
  int  send_idle_pct;
  int  stall_pct;
  bit  hold_off;

  midpoint_ellipse_rasterizer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  always @(negedge clk_i) begin
    if (hold_off) out_stall_i <= 1'b1;
    else out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) board.check_set(out_data_o);
  end

  function automatic int rand_coord();
    return $urandom_range(COORD_MAX);
  endfunction

  function automatic in_item_t make_beat(logic act, int xs, int ys, int xe, int ye);
    in_item_t b;
    b.action  = act;
    b.x_start = xs[COORD_BITS-1:0];
    b.y_start = ys[COORD_BITS-1:0];
    b.x_end   = xe[COORD_BITS-1:0];
    b.y_end   = ye[COORD_BITS-1:0];
    return b;
  endfunction

  // Called at a falling edge; returns at the falling edge after the beat is taken,
  // with valid still high so that a back-to-back beat needs no second assignment.
  task automatic send_beat(input in_item_t beat);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= beat;
    do @(posedge clk_i); while (in_stall_o);
    board.note_beat(beat);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_step();
    send_beat(make_beat(ACT_STEP, rand_coord(), rand_coord(), rand_coord(), rand_coord()));
  endtask

  task automatic set_phase(input int idle, input int stall);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    send_idle_pct = idle;
    stall_pct     = stall;
    @(negedge clk_i);
  endtask

  task automatic hold_receiver(input int cycles);
    @(posedge clk_i);
    hold_off = 1'b1;
    repeat (cycles) @(posedge clk_i);
    hold_off = 1'b0;
  endtask

  // Mostly whole ellipses: small boxes run to the end, big ones are abandoned early.
  task automatic run_random(input int quota);
    int target, dx, dy, x0, y0, xs, ys, xe, ye, tmp, limit, n;
    target = items_sent + quota;
    while (items_sent < target) begin
      if ($urandom_range(9) == 0) begin
        send_beat(make_beat(($urandom_range(1) == 1) ? ACT_STEP : ACT_START,
                            rand_coord(), rand_coord(), rand_coord(), rand_coord()));
        continue;
      end
      if ($urandom_range(19) == 0) begin
        dx    = ($urandom_range(1) == 1) ? $urandom_range(15) : rand_coord();
        dy    = rand_coord();
        limit = $urandom_range(120, 1);
      end else begin
        dx    = $urandom_range(40);
        dy    = $urandom_range(40);
        limit = ($urandom_range(7) == 0) ? $urandom_range(10) : 4 * COORD_MAX;
      end
      x0 = $urandom_range(COORD_MAX - dx);
      y0 = $urandom_range(COORD_MAX - dy);
      xs = x0;
      xe = x0 + dx;
      ys = y0;
      ye = y0 + dy;
      if ($urandom_range(1) == 1) begin
        tmp = xs; xs = xe; xe = tmp;
      end
      if ($urandom_range(1) == 1) begin
        tmp = ys; ys = ye; ye = tmp;
      end
      send_beat(make_beat(ACT_START, xs, ys, xe, ye));
      n = 0;
      while (board.drawing && n < limit && items_sent < target) begin
        send_step();
        n++;
      end
      if (!board.drawing) repeat ($urandom_range(2)) send_step();
    end
  endtask

  initial begin
    board         = new;
    items_sent    = 0;
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_off      = 1'b0;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    in_data_i     = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // step with nothing to draw, then degenerate and extreme boxes
    send_beat(make_beat(ACT_STEP, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
    send_beat(make_beat(ACT_START, 0, 0, 0, 0));
    send_step();
    send_beat(make_beat(ACT_START, COORD_MAX, COORD_MAX, 0, 0));
    send_step();
    send_step();
    // restart while the previous ellipse is still in progress
    send_beat(make_beat(ACT_START, 0, 0, COORD_MAX, COORD_MAX));
    send_step();
    send_beat(make_beat(ACT_START, 7, 300, 1000, 300));
    send_beat(make_beat(ACT_START, 10, 10, 11, 11));
    // vertical line: no horizontal radius
    send_beat(make_beat(ACT_START, 100, 10, 100, 16));
    while (board.drawing) send_step();
    send_step();
    send_beat(make_beat(ACT_START, 20, 16, 10, 10));
    while (board.drawing) send_step();
    send_step();

    set_phase(0, 0);
    run_random(450);
    set_phase(63, 0);
    run_random(450);
    set_phase(0, 63);
    run_random(450);
    set_phase(11, 11);
    run_random(400);

    // hold the output off long enough for the block to back up onto its input
    set_phase(0, 0);
    fork
      hold_receiver(300);
      run_random(60);
    join

    in_valid_i <= 1'b0;
    while (board.pending_sets.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    board.close_out();
    if (board.n_fail == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
